>>> sv/sbsm_pkg.sv
// Shared types and constants for the serial bank switch mapper.
// Used by sbsm_regs and serial_bank_switch_mapper; depends on nothing.
package sbsm_pkg;

   // Bus access kinds carried on the request tuser.
   typedef enum logic [1:0] {
      CMD_CPU_READ  = 2'd0,
      CMD_CPU_WRITE = 2'd1,
      CMD_PPU_READ  = 2'd2,
      CMD_PPU_WRITE = 2'd3
   } cmd_type;

   // Memory reached by an access, carried on the response tuser.
   typedef enum logic [2:0] {
      TGT_NONE    = 3'd0,
      TGT_PRG_ROM = 3'd1,
      TGT_PRG_RAM = 3'd2,
      TGT_CHR     = 3'd3,
      TGT_PPU     = 3'd4,
      TGT_FAULT   = 3'd5
   } target_type;

   // Mapper register picked by CPU address bits 14:13.
   typedef enum logic [1:0] {
      SEL_CONTROL  = 2'd0,
      SEL_CHR_LOW  = 2'd1,
      SEL_CHR_HIGH = 2'd2,
      SEL_PRG      = 2'd3
   } reg_sel_type;

   // PRG banking mode, control bits 3:2.
   typedef enum logic [1:0] {
      PRG_SWITCH_32K     = 2'd0,
      PRG_SWITCH_32K_ALT = 2'd1,
      PRG_FIX_LOWER      = 2'd2,
      PRG_FIX_UPPER      = 2'd3
   } prg_mode_type;

   localparam logic [4:0]  SHIFT_MARKER   = 5'h10;
   localparam logic [4:0]  CONTROL_RESET  = 5'h0C;
   localparam logic [3:0]  PRG_HIGH_RESET = 4'hF;
   localparam logic [4:0]  CHR_HIGH_RESET = 5'h01;
   localparam logic [15:0] EXP_AREA_BASE  = 16'h4020;
   localparam logic [15:0] PRG_RAM_BASE   = 16'h6000;
   localparam logic [15:0] PRG_ROM_BASE   = 16'h8000;
   localparam logic [15:0] PRG_HIGH_BASE  = 16'hC000;
   localparam logic [15:0] CHR_HIGH_BASE  = 16'h1000;
   localparam logic [15:0] PPU_INT_BASE   = 16'h2000;

   localparam int MEM_ADDR_W  = 18;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   // One serial port write as it leaves the input register.
   typedef struct packed {
      logic        valid;
      reg_sel_type sel;
      logic [7:0]  data;
   } serial_write_type;

   // Current bank windows plus the mirroring bits after this write.
   typedef struct packed {
      logic [3:0] prg_low;
      logic [3:0] prg_high;
      logic [4:0] chr_low;
      logic [4:0] chr_high;
      logic [1:0] mirroring_next;
   } map_state_type;

endpackage

>>> sv/sbsm_regs.sv
// Mapper register file: serial shift register, control and bank registers.
// Depends on sbsm_pkg.
module sbsm_regs (
   input  logic                     clock,
   input  logic                     reset,
   input  sbsm_pkg::serial_write_type wr,
   input  logic                     csr_we,
   input  logic [3:0]               csr_wdata,
   output sbsm_pkg::map_state_type  state
);
   import sbsm_pkg::*;

   logic [4:0] shift_ff, shift_in;
   logic [4:0] control_ff, control_in;
   logic [3:0] prg_low_ff, prg_low_in;
   logic [3:0] prg_high_ff, prg_high_in;
   logic [4:0] chr_low_ff, chr_low_in;
   logic [4:0] chr_high_ff, chr_high_in;
   logic [4:0] collect;
   logic       do_load;

   // Shift in LSB first; the marker reaching bit 0 means this is the fifth bit.
   assign collect = {wr.data[0], shift_ff[4:1]};

   always_comb begin
      shift_in    = shift_ff;
      control_in  = control_ff;
      prg_low_in  = prg_low_ff;
      prg_high_in = prg_high_ff;
      chr_low_in  = chr_low_ff;
      chr_high_in = chr_high_ff;
      do_load     = 1'b0;
      if (wr.valid) begin
         if (wr.data[7]) begin
            shift_in = SHIFT_MARKER;
         end else if (shift_ff[0]) begin
            shift_in = SHIFT_MARKER;
            do_load  = 1'b1;
         end else begin
            shift_in = collect;
         end
      end
      if (do_load) begin
         case (wr.sel)
            SEL_CONTROL: begin
               control_in = collect;
            end
            SEL_CHR_LOW: begin
               if (control_ff[4]) begin
                  chr_low_in = collect;
               end else begin
                  chr_low_in  = {collect[4:1], 1'b0};
                  chr_high_in = {collect[4:1], 1'b1};
               end
            end
            SEL_CHR_HIGH: begin
               if (control_ff[4]) begin
                  chr_high_in = collect;
               end
            end
            SEL_PRG: begin
               case (prg_mode_type'(control_ff[3:2]))
                  PRG_FIX_LOWER: begin
                     prg_high_in = collect[3:0];
                  end
                  PRG_FIX_UPPER: begin
                     prg_low_in = collect[3:0];
                  end
                  PRG_SWITCH_32K, PRG_SWITCH_32K_ALT: begin
                     prg_low_in  = {collect[3:1], 1'b0};
                     prg_high_in = {collect[3:1], 1'b1};
                  end
                  default: begin
                     prg_low_in = prg_low_ff;
                  end
               endcase
            end
            default: begin
               control_in = control_ff;
            end
         endcase
      end
      // New cartridge size: the fixed upper window moves to the last bank.
      if (csr_we) begin
         prg_high_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff    <= SHIFT_MARKER;
         control_ff  <= CONTROL_RESET;
         prg_low_ff  <= '0;
         prg_high_ff <= PRG_HIGH_RESET;
         chr_low_ff  <= '0;
         chr_high_ff <= CHR_HIGH_RESET;
      end else begin
         shift_ff    <= shift_in;
         control_ff  <= control_in;
         prg_low_ff  <= prg_low_in;
         prg_high_ff <= prg_high_in;
         chr_low_ff  <= chr_low_in;
         chr_high_ff <= chr_high_in;
      end
   end

   assign state.prg_low        = prg_low_ff;
   assign state.prg_high       = prg_high_ff;
   assign state.chr_low        = chr_low_ff;
   assign state.chr_high       = chr_high_ff;
   assign state.mirroring_next = control_in[1:0];

   a_marker_kept : assert property (@(posedge clock) disable iff (reset)
      shift_ff != 5'd0)
      else $error("serial shift register lost its marker bit");

   a_chr8k_pair : assert property (@(posedge clock) disable iff (reset)
      do_load && (wr.sel == SEL_CHR_LOW) && !control_ff[4]
      |=> chr_high_ff == chr_low_ff + 5'd1)
      else $error("8K CHR load did not pair the high window");

   a_clear_serial : assert property (@(posedge clock) disable iff (reset)
      wr.valid && wr.data[7] |=> shift_ff == SHIFT_MARKER)
      else $error("serial clear did not restore the marker");

   a_csr_high : assert property (@(posedge clock) disable iff (reset)
      csr_we |=> prg_high_ff == $past(csr_wdata))
      else $error("last bank write did not reach the upper PRG window");

endmodule

>>> sv/serial_bank_switch_mapper.sv
// Top level of the serial bank switch mapper: request/response pipeline and
// address translation. Depends on sbsm_pkg and sbsm_regs.
//
// Cartridge bank mapper of the serial-load kind. Each request is one CPU or
// PPU bus access; each produces exactly one response naming the memory it
// reaches, the byte offset inside it, a write strobe with data, and the
// current mirroring bits. CPU writes at 0x8000 and above shift one bit into
// the serial port (data bit 7 clears it); every fifth bit loads control,
// CHR low, CHR high or PRG bank as picked by address bits 14:13. Such writes
// answer with target none. The block takes one request per clock cycle while
// rsp_tready is high; a request is held in the input register, and its response
// is offered from the response register: the mapper registers update and the
// translation is computed as it moves into the response register. A held
// response stalls the input register; req_tready drops only while both
// registers are full and rsp_tready is low.
// Translation uses the banks in force before the request;
// the mirroring bits reflect any control load made by the request itself.
// The csr port writes the last PRG bank index and sets the upper PRG window
// to it; write it only while no request is in flight.
module serial_bank_switch_mapper (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sbsm_pkg::REQ_TDATA_W-1:0]   req_tdata,  // address[15:0], data[23:16]
   input  logic [1:0]                         req_tuser,  // cmd[1:0]
   // Response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sbsm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // mem_addr[17:0],
                                                          // write_enable[18],
                                                          // write_data[26:19],
                                                          // mirroring[28:27], zero
   output logic [2:0]                         rsp_tuser,  // target[2:0]
   // Configuration
   input  logic                               csr_we,
   input  logic [3:0]                         csr_wdata   // prg_last_bank
);
   import sbsm_pkg::*;

   // Input register
   logic                  s1_valid_ff, s1_valid_in;
   cmd_type               s1_cmd_ff, s1_cmd_in;
   logic [15:0]           s1_addr_ff, s1_addr_in;
   logic [7:0]            s1_data_ff, s1_data_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   target_type            rsp_target_ff, rsp_target_in;
   logic [MEM_ADDR_W-1:0] rsp_maddr_ff, rsp_maddr_in;
   logic                  rsp_we_ff, rsp_we_in;
   logic [7:0]            rsp_wdata_ff, rsp_wdata_in;
   logic [1:0]            rsp_mirror_ff, rsp_mirror_in;

   logic                  req_acc;
   logic                  out_free;
   logic                  s1_adv;
   serial_write_type      wr;
   map_state_type         mstate;

   // Advance the input register whenever the response slot is empty or
   // being drained this cycle; accept a new request into the freed slot.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_acc    = req_tvalid && req_tready;

   assign s1_valid_in = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign s1_cmd_in   = cmd_type'(req_tuser);
   assign s1_addr_in  = req_tdata[15:0];
   assign s1_data_in  = req_tdata[23:16];

   // Serial port write: only as the request moves on, so it fires once.
   assign wr.valid = s1_adv && (s1_cmd_ff == CMD_CPU_WRITE) && s1_addr_ff[15];
   assign wr.sel   = reg_sel_type'(s1_addr_ff[14:13]);
   assign wr.data  = s1_data_ff;

   sbsm_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .state     (mstate)
   );

   // Address translation
   always_comb begin
      rsp_target_in = TGT_NONE;
      rsp_maddr_in  = '0;
      rsp_we_in     = 1'b0;
      case (s1_cmd_ff)
         CMD_CPU_READ: begin
            if (s1_addr_ff >= PRG_HIGH_BASE) begin
               rsp_target_in = TGT_PRG_ROM;
               rsp_maddr_in  = {mstate.prg_high, s1_addr_ff[13:0]};
            end else if (s1_addr_ff >= PRG_ROM_BASE) begin
               rsp_target_in = TGT_PRG_ROM;
               rsp_maddr_in  = {mstate.prg_low, s1_addr_ff[13:0]};
            end else if (s1_addr_ff >= PRG_RAM_BASE) begin
               rsp_target_in = TGT_PRG_RAM;
               rsp_maddr_in  = {5'd0, s1_addr_ff[12:0]};
            end else begin
               rsp_target_in = TGT_FAULT;
            end
         end
         CMD_CPU_WRITE: begin
            if (s1_addr_ff >= PRG_ROM_BASE) begin
               // Serial port: no memory access.
               rsp_target_in = TGT_NONE;
            end else if (s1_addr_ff >= PRG_RAM_BASE) begin
               rsp_target_in = TGT_PRG_RAM;
               rsp_maddr_in  = {5'd0, s1_addr_ff[12:0]};
               rsp_we_in     = 1'b1;
            end else if (s1_addr_ff >= EXP_AREA_BASE) begin
               // Expansion area: drop the write.
               rsp_target_in = TGT_NONE;
            end else begin
               rsp_target_in = TGT_FAULT;
            end
         end
         CMD_PPU_READ, CMD_PPU_WRITE: begin
            if (s1_addr_ff < CHR_HIGH_BASE) begin
               rsp_target_in = TGT_CHR;
               rsp_maddr_in  = {1'b0, mstate.chr_low, s1_addr_ff[11:0]};
            end else if (s1_addr_ff < PPU_INT_BASE) begin
               rsp_target_in = TGT_CHR;
               rsp_maddr_in  = {1'b0, mstate.chr_high, s1_addr_ff[11:0]};
            end else begin
               rsp_target_in = TGT_PPU;
               rsp_maddr_in  = {2'd0, s1_addr_ff};
            end
            rsp_we_in = (s1_cmd_ff == CMD_PPU_WRITE);
         end
         default: begin
            rsp_target_in = TGT_FAULT;
         end
      endcase
   end

   assign rsp_wdata_in  = rsp_we_in ? s1_data_ff : 8'd0;
   assign rsp_mirror_in = mstate.mirroring_next;
   assign rsp_valid_in  = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: hold unless their stage loads.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_cmd_ff  <= s1_cmd_in;
         s1_addr_ff <= s1_addr_in;
         s1_data_ff <= s1_data_in;
      end
      if (s1_adv) begin
         rsp_target_ff <= rsp_target_in;
         rsp_maddr_ff  <= rsp_maddr_in;
         rsp_we_ff     <= rsp_we_in;
         rsp_wdata_ff  <= rsp_wdata_in;
         rsp_mirror_ff <= rsp_mirror_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_target_ff;
   assign rsp_tdata  = {3'd0, rsp_mirror_ff, rsp_wdata_ff, rsp_we_ff, rsp_maddr_ff};

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      req_acc && s1_valid_ff |-> s1_adv)
      else $error("input register overwritten before it advanced");

   a_serial_none : assert property (@(posedge clock) disable iff (reset)
      wr.valid |=> rsp_tuser == TGT_NONE && !rsp_tdata[18])
      else $error("serial port write produced a memory access");

   a_wdata_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_we_ff |-> rsp_wdata_ff == 8'd0)
      else $error("write data not cleared without a strobe");

endmodule
